FILE: design/lpp_pkg.sv
// Shared types, constants and codes of the laser power PID block.
package lpp_pkg;

	localparam int TEMP_W  = 17;
	localparam int SPEED_W = 16;
	localparam int POWER_W = 15;
	localparam int ERR_W   = 18;
	localparam int INTEG_W = 17;
	localparam int DIFF_W  = 19;
	localparam int SUM_W   = 22;
	localparam int PROD_W  = 33;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 32;

	localparam logic [CFG_AW-3+1:0] REG_TARGET_TEMP = '0;

	localparam int INTEGRAL_LIMIT  = 32000;
	localparam int SPEED_LIMIT     = 3840;
	localparam int POWER_MIN       = 800;
	localparam int POWER_MAX       = 19200;
	localparam int OVERTEMP_MARGIN = 9600;

	// Quotient bits produced by the divider, one per cycle.
	localparam int DIV_STEPS = POWER_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic               scan_start;
		logic [TEMP_W-1:0]  measured_temp;
		logic [SPEED_W-1:0] scan_speed;
	} in_word_t;

	typedef struct packed {
		logic [POWER_W-1:0] drive_power;
		logic               over_temp;
	} out_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ERR,
		S_PWR,
		S_MUL,
		S_CHK,
		S_DIV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic upd_state;
		logic calc_power;
		logic calc_prod;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic go_div;
	} sts_t;

endpackage

FILE: design/lpp_ctrl.sv
// Sequencer of the laser power PID block: state machine, divide step counter, output valid.
module lpp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output lpp_pkg::cmd_t cmd,
	input  lpp_pkg::sts_t sts
);
	import lpp_pkg::*;

	state_t               state_q;
	state_t               state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 div_last;
	logic                 out_valid_q;
	logic                 out_free;

	assign div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_ERR;
				end
			end
			S_ERR: state_d = S_PWR;
			S_PWR: state_d = S_MUL;
			S_MUL: state_d = S_CHK;
			S_CHK: state_d = sts.go_div ? S_DIV : S_FIN;
			S_DIV: begin
				if (div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_ERR: cmd.upd_state  = 1'b1;
			S_PWR: cmd.calc_power = 1'b1;
			S_MUL: cmd.calc_prod  = 1'b1;
			S_CHK: cmd.div_init   = 1'b1;
			S_DIV: cmd.div_step   = 1'b1;
			S_FIN: cmd.out_load   = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// An accepted word always starts the error stage.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_ERR)
		else $error("accepted word did not start the error stage");

	// The divider runs its full number of steps.
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && !div_last |=> state_q == S_DIV)
		else $error("divider left early");

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// The finished result waits while the receiver stalls.
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && out_valid_q && !out_ready |=> state_q == S_FIN)
		else $error("finish stage left while output stalled");

endmodule

FILE: design/lpp_dp.sv
// Datapath of the laser power PID block: PID state, power sum, derating divider, clamps.
module lpp_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lpp_pkg::cmd_t              cmd,
	output lpp_pkg::sts_t              sts,
	input  lpp_pkg::in_word_t          in_word,
	input  logic [lpp_pkg::TEMP_W-1:0] target_temp,
	output lpp_pkg::out_word_t         out_word
);
	import lpp_pkg::*;

	// Latched input word.
	logic               start_q;
	logic [TEMP_W-1:0]  meas_q;
	logic [SPEED_W-1:0] speed_q;

	// Controller state carried between segments.
	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic                      flag_q;

	// Per-segment working registers.
	logic signed [ERR_W-1:0]  err_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [SUM_W-1:0]  power_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     pos_q;
	logic                     derate_q;
	logic                     sat_q;
	logic [SPEED_W-1:0]       rem_q;
	logic [POWER_W-1:0]       quo_q;
	out_word_t                out_q;

	logic signed [ERR_W-1:0]   prev_eff;
	logic signed [INTEG_W-1:0] integ_eff;
	logic                      flag_eff;
	logic signed [ERR_W-1:0]   err_c;
	logic signed [ERR_W:0]     isum_c;
	logic signed [INTEG_W-1:0] integ_c;
	logic signed [DIFF_W-1:0]  diff_c;
	logic [ERR_W-1:0]          limit_c;
	logic                      hot_c;

	logic signed [SUM_W-1:0]  p_kp;
	logic signed [SUM_W-1:0]  p_int;
	logic signed [DIFF_W+1:0] d3;
	logic signed [SUM_W-1:0]  p_der;
	logic signed [SUM_W-1:0]  sum_c;

	logic [PROD_W-1:0]  prod_c;
	logic [PROD_W-1:0]  div_top;
	logic               sat_c;
	logic [SPEED_W:0]   trial;
	logic               take;
	logic [POWER_W-1:0] res_c;

	// Error stage: scan start discards the history before this segment.
	assign prev_eff  = start_q ? '0 : prev_err_q;
	assign integ_eff = start_q ? '0 : integ_q;
	assign flag_eff  = start_q ? 1'b0 : flag_q;
	assign err_c     = $signed({1'b0, target_temp}) - $signed({1'b0, meas_q});
	assign isum_c    = ERR_W'(integ_eff) + err_c;
	assign diff_c    = DIFF_W'(err_c) - DIFF_W'(prev_eff);
	assign limit_c   = ERR_W'(target_temp) + ERR_W'(OVERTEMP_MARGIN);
	assign hot_c     = ERR_W'(meas_q) > limit_c;

	always_comb begin
		if (isum_c > (ERR_W+1)'(INTEGRAL_LIMIT)) begin
			integ_c = INTEG_W'(INTEGRAL_LIMIT);
		end else if (isum_c < -(ERR_W+1)'(INTEGRAL_LIMIT)) begin
			integ_c = -INTEG_W'(INTEGRAL_LIMIT);
		end else begin
			integ_c = isum_c[INTEG_W-1:0];
		end
	end

	// Power stage: both halvings are arithmetic shifts, so they round toward minus infinity.
	assign p_kp  = {err_q[ERR_W-1], err_q, 3'b000};
	assign p_int = SUM_W'(integ_q >>> 1);
	assign d3    = (DIFF_W+2)'(diff_q) + $signed({diff_q[DIFF_W-1], diff_q, 1'b0});
	assign p_der = SUM_W'(d3 >>> 1);
	assign sum_c = p_kp + p_int + p_der;

	// 3840 = 4096 - 256, so the derating product is two shifts and a subtract.
	assign prod_c = {power_q[SUM_W-2:0], 12'b0} - {4'b0, power_q[SUM_W-2:0], 8'b0};

	// Quotients of 2^15 or more saturate, which keeps the divider to fifteen steps.
	assign div_top = {2'b0, speed_q, 15'b0};
	assign sat_c   = prod_q >= div_top;
	assign sts.go_div = derate_q && pos_q && !sat_c;

	assign trial = {rem_q, quo_q[POWER_W-1]};
	assign take  = trial >= {1'b0, speed_q};

	always_comb begin
		if (derate_q) begin
			if (!pos_q) begin
				res_c = POWER_W'(POWER_MIN);
			end else if (sat_q || quo_q > POWER_W'(POWER_MAX)) begin
				res_c = POWER_W'(POWER_MAX);
			end else if (quo_q < POWER_W'(POWER_MIN)) begin
				res_c = POWER_W'(POWER_MIN);
			end else begin
				res_c = quo_q;
			end
		end else begin
			if (power_q < SUM_W'(POWER_MIN)) begin
				res_c = POWER_W'(POWER_MIN);
			end else if (power_q > SUM_W'(POWER_MAX)) begin
				res_c = POWER_W'(POWER_MAX);
			end else begin
				res_c = power_q[POWER_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
			flag_q     <= 1'b0;
		end else if (cmd.upd_state) begin
			prev_err_q <= err_c;
			integ_q    <= integ_c;
			flag_q     <= flag_eff | hot_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= in_word.scan_start;
			meas_q  <= in_word.measured_temp;
			speed_q <= in_word.scan_speed;
		end
		if (cmd.upd_state) begin
			err_q  <= err_c;
			diff_q <= diff_c;
		end
		if (cmd.calc_power) begin
			power_q <= sum_c;
		end
		if (cmd.calc_prod) begin
			prod_q   <= prod_c;
			pos_q    <= !power_q[SUM_W-1] && (power_q != '0);
			derate_q <= speed_q > SPEED_W'(SPEED_LIMIT);
		end
		if (cmd.div_init) begin
			sat_q <= sat_c;
			rem_q <= prod_q[PROD_W-3:POWER_W];
			quo_q <= prod_q[POWER_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= take ? SPEED_W'(trial - {1'b0, speed_q}) : trial[SPEED_W-1:0];
			quo_q <= {quo_q[POWER_W-2:0], take};
		end
		if (cmd.out_load) begin
			out_q.drive_power <= res_c;
			out_q.over_temp   <= flag_q;
		end
	end

	assign out_word = out_q;

endmodule

FILE: design/laser_power_pid_core.sv
// Top level of the laser power PID block: configuration register, controller and datapath.
//
// Usage: each scan segment enters as one input word (scan_start, measured_temp,
// scan_speed) on the in_valid/in_ready channel, and exactly one result word
// (drive_power, over_temp) leaves on the out_valid/out_ready channel for it.
// The target temperature is written through the APB-style port at byte
// address 0; the user must write it only while the block is idle, and the
// block itself has no guard for this. pready is always high and reads return the register.
// Flow: an accepted word passes the error, power, product and check states, and the
// finish state then loads the output register. With derating (speed above 15 mm/s
// and a positive PID sum that does not saturate the quotient) a restoring divider
// between the check and finish states produces one quotient bit per cycle until
// the fifteen-bit quotient is complete. The sequencer takes no new word before the
// previous result has been loaded into the output register.
// A new word is accepted only while the sequencer is idle, but the result
// register decouples the sides: the next word is accepted and worked on while
// the previous result still waits. When the receiver stalls, the finished
// result holds in the final stage until the output register is free.
// Reset clears the target temperature, the error history, the integral, the
// over-temperature flag and all handshake state; no result is pending after it.
module laser_power_pid_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  lpp_pkg::in_word_t          in_word,
	output logic                       out_valid,
	input  logic                       out_ready,
	output lpp_pkg::out_word_t         out_word,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lpp_pkg::CFG_AW-1:0] paddr,
	input  logic [lpp_pkg::CFG_DW-1:0] pwdata,
	output logic [lpp_pkg::CFG_DW-1:0] prdata,
	output logic                       pready
);
	import lpp_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [TEMP_W-1:0] target_temp_q;
	logic              cfg_wr;

	// The only register occupies the whole address space, so every aligned
	// access lands on the target temperature.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && ((paddr >> 2) == CFG_AW'(REG_TARGET_TEMP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_temp_q <= '0;
		end else if (cfg_wr) begin
			target_temp_q <= pwdata[TEMP_W-1:0];
		end
	end

	assign prdata = CFG_DW'(target_temp_q);

	// The sequencer steps the datapath through the error, power, product and clamp
	// stages of one segment, with the divide stage between them only when go_div is set.
	lpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lpp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_word     (in_word),
		.target_temp (target_temp_q),
		.out_word    (out_word)
	);

endmodule
